// ----- rtl/ssr_pkg.sv -----
// shared constants and types for the streaming substring replace block
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  localparam int LEN_W     = 4;
  localparam int WORD_W    = 64;
  localparam int CFG_IDX_W = 4;

  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 4'd3;

  // one text byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ssr_item_t;

  // settings seen by the back end
  typedef struct packed {
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [WORD_W-1:0] repl;
    logic              clear;
  } ssr_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/ssr_if.sv -----
// valid/ready channel interfaces for input, result and configuration
`timescale 1ns / 1ps
`default_nettype none

interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ssr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                  output ready);
endinterface

interface ssr_cfg_if;
  import ssr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ssr_front.sv -----
// front end: accepts text bytes, compares each against every pattern byte, queues them
`timescale 1ns / 1ps
`default_nettype none

module ssr_front #(
  parameter int MAX_PATTERN = ssr_pkg::DEF_MAX_PATTERN
) (
  input  wire                       clk,
  input  wire                       rst_n,
  ssr_in_if.sink                    in_ch,
  input  wire [ssr_pkg::WORD_W-1:0] pattern_bytes,
  output logic                      q_valid,
  output ssr_pkg::ssr_item_t        q_item,
  output logic [MAX_PATTERN-1:0]    q_eq,
  input  wire                       q_pop
);
  import ssr_pkg::*;

  ssr_item_t              item_r [2];
  logic [MAX_PATTERN-1:0] eq_r   [2];
  logic                   wr_ptr_r;
  logic                   rd_ptr_r;
  logic [1:0]             cnt_r;
  logic [MAX_PATTERN-1:0] eq_in;
  logic                   push;

  // per-position byte compare, tagged onto the byte
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      eq_in[j] = (in_ch.in_byte == pattern_bytes[j*8 +: 8]);
    end
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = item_r[rd_ptr_r];
  assign q_eq        = eq_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wr_ptr_r] <= '{data: in_ch.in_byte, last: in_ch.in_last};
      eq_r[wr_ptr_r]   <= eq_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssr_back.sv -----
// back end: pending buffer, match sequencer, one-result hold stage and output register
`timescale 1ns / 1ps
`default_nettype none

module ssr_back #(
  parameter int MAX_PATTERN     = ssr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = ssr_pkg::DEF_MAX_REPLACEMENT
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  ssr_pkg::ssr_cfg_t      cfg,
  input  wire                    q_valid,
  input  ssr_pkg::ssr_item_t     q_item,
  input  wire [MAX_PATTERN-1:0]  q_eq,
  output logic                   q_pop,
  ssr_out_if.source              out_ch
);
  import ssr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int RIDX_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_REPL = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [7:0]             buf_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eqv_r [MAX_PATTERN];
  logic [CNT_W-1:0]       cnt_r;
  logic                   last_r;
  logic [RIDX_W-1:0]      ridx_r;
  logic                   hold_v_r;
  logic [7:0]             hold_byte_r;
  logic                   out_v_r;
  logic [7:0]             out_byte_r;
  logic                   out_bv_r;
  logic                   out_last_r;

  logic [LEN_W-1:0] cnt_ext;
  logic             prefix_ok;
  logic             full_match;
  logic             wait_more;
  logic             item_done;
  logic             out_free;
  logic             emit_ok;
  logic             do_emit;
  logic             do_shift;
  logic             do_match;
  logic             do_close;
  logic [7:0]       emit_byte;
  logic             out_load;

  assign cnt_ext = LEN_W'(cnt_r);

  // pending bytes still agree with the head of the pattern
  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < cnt_ext && LEN_W'(i) < cfg.plen && !eqv_r[i][i]) prefix_ok = 1'b0;
    end
  end

  assign full_match = (cfg.plen != '0) && (cnt_ext >= cfg.plen) && prefix_ok;
  assign wait_more  = (cfg.plen != '0) && prefix_ok && !last_r && !full_match;
  assign item_done  = (cnt_ext == '0) || wait_more;
  assign out_free   = !out_v_r || out_ch.ready;
  assign emit_ok    = !hold_v_r || out_free;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    do_emit   = 1'b0;
    do_shift  = 1'b0;
    do_match  = 1'b0;
    do_close  = 1'b0;
    emit_byte = buf_r[0];
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (item_done) begin
          if (!(hold_v_r || last_r) || out_free) begin
            do_close  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (full_match) begin
          do_match  = 1'b1;
          state_nxt = (cfg.rlen != '0) ? ST_REPL : ST_SCAN;
        end else if (emit_ok) begin
          do_emit  = 1'b1;
          do_shift = 1'b1;
        end
      end
      ST_REPL: begin
        emit_byte = cfg.repl[{ridx_r, 3'b000} +: 8];
        if (emit_ok) begin
          do_emit = 1'b1;
          if (LEN_W'(ridx_r) + LEN_W'(1) == cfg.rlen) state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the held result leaves once its successor exists or the item closes
  assign out_load = (do_emit && hold_v_r) || (do_close && (hold_v_r || last_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      last_r   <= 1'b0;
      ridx_r   <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.clear) cnt_r <= '0;
      else if (q_pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_match) cnt_r <= '0;
      else if (do_shift) cnt_r <= cnt_r - CNT_W'(1);
      if (q_pop) last_r <= q_item.last;
      if (do_match) ridx_r <= '0;
      else if (do_emit && state_r == ST_REPL) ridx_r <= ridx_r + RIDX_W'(1);
      if (do_emit) hold_v_r <= 1'b1;
      else if (do_close) hold_v_r <= 1'b0;
      if (out_load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r[cnt_r[IDX_W-1:0]] <= q_item.data;
      eqv_r[cnt_r[IDX_W-1:0]] <= q_eq;
    end else if (do_shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
        eqv_r[i] <= eqv_r[i+1];
      end
    end
    if (do_emit) hold_byte_r <= emit_byte;
    if (out_load) begin
      if (do_close && !hold_v_r) begin
        out_byte_r <= 8'd0;
        out_bv_r   <= 1'b0;
        out_last_r <= 1'b1;
      end else begin
        out_byte_r <= hold_byte_r;
        out_bv_r   <= 1'b1;
        out_last_r <= do_close && last_r;
      end
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = out_bv_r;
  assign out_ch.out_last   = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/stream_substring_replace_top.sv -----
// top level of the streaming substring replace block
// path: a byte that passes straight through is queued by its input transaction, then
//   popped, scanned into the hold stage and closed into the output register
// sequencing: the back end sequencer works on one popped byte at a time (pop, emits,
//   matches, close), the two-entry front queue takes further bytes; output stalls hold it up
// reset: synchronous, active low; clears control and settings, pending store left stale
`timescale 1ns / 1ps
`default_nettype none

module stream_substring_replace_top #(
  parameter int MAX_PATTERN     = ssr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = ssr_pkg::DEF_MAX_REPLACEMENT
) (
  input  wire        clk,
  input  wire        rst_n,
  ssr_in_if.sink     in_ch,
  ssr_out_if.source  out_ch,
  ssr_cfg_if.sink    cfg_ch
);
  import ssr_pkg::*;

  // settings registers
  logic [WORD_W-1:0] pattern_bytes_r;
  logic [LEN_W-1:0]  pattern_length_r;
  logic [WORD_W-1:0] replacement_bytes_r;
  logic [LEN_W-1:0]  replacement_length_r;
  logic              cfg_hit;
  logic              cfg_wr;

  ssr_cfg_t               cfg;
  logic                   q_valid;
  ssr_item_t              q_item;
  logic [MAX_PATTERN-1:0] q_eq;
  logic                   q_pop;

  // settings are taken every cycle; the user must keep writes between texts, unchecked here
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  // known register index, unknown ones leave everything alone
  always_comb begin
    unique case (cfg_ch.reg_index) inside
      REG_PATTERN_BYTES, REG_PATTERN_LENGTH,
      REG_REPLACEMENT_BYTES, REG_REPLACEMENT_LENGTH: cfg_hit = 1'b1;
      default:                                       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r      <= '0;
      pattern_length_r     <= '0;
      replacement_bytes_r  <= '0;
      replacement_length_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_ch.reg_index)
        REG_PATTERN_BYTES:      pattern_bytes_r      <= cfg_ch.wr_data;
        REG_PATTERN_LENGTH:     pattern_length_r     <= cfg_ch.wr_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes_r  <= cfg_ch.wr_data;
        REG_REPLACEMENT_LENGTH: replacement_length_r <= cfg_ch.wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized lengths saturate at the buffer sizes; any known write drops pending bytes
  assign cfg.plen  = (pattern_length_r > LEN_W'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : pattern_length_r;
  assign cfg.rlen  = (replacement_length_r > LEN_W'(MAX_REPLACEMENT)) ?
                     LEN_W'(MAX_REPLACEMENT) : replacement_length_r;
  assign cfg.repl  = replacement_bytes_r;
  assign cfg.clear = cfg_wr && cfg_hit;

  // front: classify each byte against the pattern and queue it
  ssr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .pattern_bytes (pattern_bytes_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_eq          (q_eq),
    .q_pop         (q_pop)
  );

  // back: match, replace, flush and deliver results
  ssr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_eq    (q_eq),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/ssr_checker.sv -----
// port-level checks for the streaming substring replace block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ssr_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       byte_valid,
  input wire       out_last
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(out_last))
    else $error("result changed while stalled");

  // a byte-less result only ever closes a text, with a zero byte
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> out_last && out_byte == 8'd0)
    else $error("bare end marker not final or not zero");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind stream_substring_replace_top ssr_checker u_ssr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .out_last   (out_ch.out_last)
);

`default_nettype wire

// ----- tb/tb_stream_substring_replace_top.sv -----
// self-checking testbench for the streaming substring replace top level
`timescale 1ns / 1ps

module tb_stream_substring_replace_top;
  import ssr_pkg::*;

  // run shape
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int QUIET_CYCLES = 40;      // drain wait after the last expected result
  localparam int LONG_HOLD    = 400;     // output hold-off in the pressure phase
  localparam int PRESS_PHASE  = 4;
  localparam int LIMIT_CYCLES = 300000;

  // an index outside the register map, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'hF;

  // length settings walked by the random phases, extremes and oversized values included
  localparam int PLEN_PLAN [RAND_PHASES] = '{8, 1, 0, 3, 15, 5, 2, 6};
  localparam int RLEN_PLAN [RAND_PHASES] = '{8, 0, 2, 12, 1, 8, 0, 4};

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } text_res_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [WORD_W-1:0]     wdata;
    logic [7:0]            data;
    logic                  last;
    logic                  typed;   // use the typed-in result instead of the predictor
    text_res_t             want;
  } dir_row_t;

  localparam int DIR_ROWS = 31;

  // directed part: pass through after reset, a short pattern with recheck after a
  // mismatch, a match closing the text, an empty replacement giving a bare end marker,
  // then oversized lengths with a full eight byte replacement on one transaction
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{ROW_CFG, REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_PATTERN_BYTES, 64'h6261, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_REPLACEMENT_BYTES, 64'h5A5958, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h78, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h61, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h62, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h61, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h61, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h62, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h61, 1'b1, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h61, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h62, 1'b1, 1'b0, '0},
    '{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h61, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'h62, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ROW_CFG, REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_PATTERN_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_REPLACEMENT_BYTES, 64'h0706_0504_0302_0100, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_REPLACEMENT_LENGTH, 64'd12, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b1, 1'b0, '0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ssr_in_if  in_if ();
  ssr_out_if out_if ();
  ssr_cfg_if cfg_if ();

  stream_substring_replace_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // idling mix, set between phases
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_go       = 1'b0;
  bit hold_on       = 1'b0;

  // bookkeeping
  int err_cnt      = 0;
  int bytes_sent   = 0;
  int texts_sent   = 0;
  int cfg_writes   = 0;
  int results_seen = 0;
  int bare_seen    = 0;
  int cycle_cnt    = 0;

  // expected output text, oldest first
  text_res_t expected_text_q [$];
  text_res_t step_out_q [$];

  // predictor copy of the settings and the waiting bytes
  logic [WORD_W-1:0] pat_reg      = '0;
  logic [LEN_W-1:0]  pat_len_reg  = '0;
  logic [WORD_W-1:0] repl_reg     = '0;
  logic [LEN_W-1:0]  repl_len_reg = '0;
  logic [7:0]        held [8];
  int                held_n       = 0;

  function automatic int clamp_len(input logic [LEN_W-1:0] v, input int cap);
    return (int'(v) > cap) ? cap : int'(v);
  endfunction

  function automatic void drop_held(input int k);
    if (k >= held_n) begin
      held_n = 0;
    end else begin
      for (int i = 0; i + k < held_n; i++) held[i] = held[i + k];
      held_n -= k;
    end
  endfunction

  // a write to a mapped register throws the waiting bytes away
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] d);
    case (idx)
      REG_PATTERN_BYTES:      pat_reg      = d;
      REG_PATTERN_LENGTH:     pat_len_reg  = d[LEN_W-1:0];
      REG_REPLACEMENT_BYTES:  repl_reg     = d;
      REG_REPLACEMENT_LENGTH: repl_len_reg = d[LEN_W-1:0];
      default: ;
    endcase
    if (idx <= REG_REPLACEMENT_LENGTH) held_n = 0;
  endfunction

  // results of one input byte into step_out_q
  function automatic void replace_step(input logic [7:0] data, input logic last);
    int plen;
    int rlen;
    int span;
    bit prefix;
    bit scan;
    plen = clamp_len(pat_len_reg, DEF_MAX_PATTERN);
    rlen = clamp_len(repl_len_reg, DEF_MAX_REPLACEMENT);
    if (held_n < 8) begin
      held[held_n] = data;
      held_n++;
    end
    scan = 1'b1;
    while (scan && held_n > 0) begin
      // an empty pattern never counts as a prefix, so every byte goes straight out
      prefix = (plen != 0);
      span   = (held_n < plen) ? held_n : plen;
      for (int i = 0; i < span; i++)
        if (held[i] != pat_reg[8*i +: 8]) prefix = 1'b0;
      if (prefix && held_n >= plen) begin
        for (int i = 0; i < rlen; i++)
          step_out_q.insert(step_out_q.size(), text_res_t'{repl_reg[8*i +: 8], 1'b1, 1'b0});
        drop_held(plen);
      end else if (prefix) begin
        scan = 1'b0;
      end else begin
        step_out_q.insert(step_out_q.size(), text_res_t'{held[0], 1'b1, 1'b0});
        drop_held(1);
      end
    end
    if (last) begin
      for (int i = 0; i < held_n; i++)
        step_out_q.insert(step_out_q.size(), text_res_t'{held[i], 1'b1, 1'b0});
      held_n = 0;
      if (step_out_q.size() == 0) step_out_q.insert(0, text_res_t'{8'h00, 1'b0, 1'b0});
      step_out_q[step_out_q.size() - 1].last = 1'b1;
    end
  endfunction

  // offer one byte, with random idle cycles ahead of it, and book its results
  task automatic push_byte(input logic [7:0] data, input logic last,
                           input logic typed, input text_res_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= data;
    in_if.in_last <= last;
    do @(posedge clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
    step_out_q.delete();
    replace_step(data, last);
    if (typed) expected_text_q.insert(expected_text_q.size(), want);
    else foreach (step_out_q[i]) expected_text_q.insert(expected_text_q.size(), step_out_q[i]);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  // valid stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= d;
    do @(posedge clk); while (!(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1));
    apply_reg(idx, d);
    cfg_writes++;
  endtask

  // idle the input, wait for every expected result, then let the back end drain
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // output side: check each result transaction, then pick next cycle's ready
  always @(posedge clk) begin : result_side
    text_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        results_seen++;
        if (out_if.byte_valid === 1'b0) bare_seen++;
        if (expected_text_q.size() == 0) begin
          $error("unexpected result: out_byte %02h byte_valid %0b out_last %0b",
                 out_if.out_byte, out_if.byte_valid, out_if.out_last);
          err_cnt++;
        end else begin
          want = expected_text_q.pop_front();
          if (out_if.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_if.out_byte);
            err_cnt++;
          end
          if (out_if.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_if.byte_valid);
            err_cnt++;
          end
          if (out_if.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_if.out_last);
            err_cnt++;
          end
        end
      end
      out_if.ready <= !hold_on && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // long output hold-off so the block fills up and pushes back on its input
  initial begin : long_hold
    wait (hold_go);
    hold_on <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_on <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int               phase;
    int               phase_start;
    int               eff_plen;
    int               tgt;
    int               pick;
    int               cut;
    int               k;
    bit               cfg_open;
    logic [7:0]       alpha [3];
    logic [7:0]       txt [$];
    logic [WORD_W-1:0] d;

    // known values on the driven inputs from time zero, ready comes from the output side
    in_if.valid      = 1'b0;
    in_if.in_byte    = '0;
    in_if.in_last    = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wr_data   = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    settle_block();
    cfg_open = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle_block();
          cfg_open = 1'b1;
        end
        write_reg(dir_tab[i].reg_idx, dir_tab[i].wdata);
      end else begin
        if (cfg_open) begin
          cfg_if.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        push_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random phases: each one a fresh setting and an idling mix
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      settle_block();
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 59; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 59; end
        default: begin in_idle_pct = 24; out_stall_pct = 24; end
      endcase

      // small alphabet so that patterns overlap themselves and texts hit them often
      foreach (alpha[j]) alpha[j] = 8'($urandom);
      eff_plen = (PLEN_PLAN[phase] > DEF_MAX_PATTERN) ? DEF_MAX_PATTERN : PLEN_PLAN[phase];

      // a stray write first, it must leave everything alone
      write_reg(4'($urandom_range(REG_NONE, REG_REPLACEMENT_LENGTH + 1)),
                {$urandom, $urandom});
      d = {$urandom, $urandom};
      for (k = 0; k < eff_plen; k++) d[8*k +: 8] = alpha[$urandom_range(2)];
      write_reg(REG_PATTERN_BYTES, d);
      d = {$urandom, $urandom};
      d[LEN_W-1:0] = LEN_W'(PLEN_PLAN[phase]);
      write_reg(REG_PATTERN_LENGTH, d);
      write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      d = {$urandom, $urandom};
      d[LEN_W-1:0] = LEN_W'(RLEN_PLAN[phase]);
      write_reg(REG_REPLACEMENT_LENGTH, d);
      cfg_if.valid <= 1'b0;

      if (phase == PRESS_PHASE) hold_go <= 1'b1;

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        // mostly short texts, now and then a long one
        txt.delete();
        tgt = ($urandom_range(9) == 0) ? $urandom_range(48, 20) : $urandom_range(12, 1);
        while (txt.size() < tgt) begin
          pick = $urandom_range(99);
          if (pick < 40 && eff_plen > 0) begin
            // whole occurrence
            for (k = 0; k < eff_plen; k++) txt.insert(txt.size(), pat_reg[8*k +: 8]);
          end else if (pick < 65 && eff_plen > 1) begin
            // broken occurrence, a proper prefix only
            cut = $urandom_range(eff_plen - 1, 1);
            for (k = 0; k < cut; k++) txt.insert(txt.size(), pat_reg[8*k +: 8]);
          end else if (pick < 85) begin
            txt.insert(txt.size(), alpha[$urandom_range(2)]);
          end else begin
            txt.insert(txt.size(), 8'($urandom));
          end
        end
        for (k = 0; k < txt.size(); k++)
          push_byte(txt[k], k == txt.size() - 1, 1'b0, '0);
      end
    end

    settle_block();

    $display("covered %0d bytes in %0d texts with %0d register writes, %0d results checked",
             bytes_sent, texts_sent, cfg_writes, results_seen);
    $display("bare end markers %0d, one long output hold-off, four idling mixes",
             bare_seen);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
